// ===== hdl/apcm_pkg.sv =====
// Shared constants, types and key functions for the adaptive palette color matcher.
`timescale 1ns / 1ps
`default_nettype none

package apcm_pkg;

  localparam int unsigned PaletteEntriesDefault = 16;

  localparam int unsigned PixelW    = 32;
  localparam int unsigned RgbW      = 24;
  localparam int unsigned IdxOutW   = 4;
  localparam int unsigned UsedW     = 5;
  localparam int unsigned CoarseKeyW = 6;
  localparam int unsigned FineKeyW  = 3;

  // Output beat layout: tdata = {pad, used_entries, added_color, color_index}.
  localparam int unsigned OutDataBits = IdxOutW + RgbW + UsedW;
  localparam int unsigned OutDataW    = ((OutDataBits + 7) / 8) * 8;
  localparam int unsigned OutUserW    = 2;
  localparam int unsigned UserAddedBit    = 0;
  localparam int unsigned UserFallbackBit = 1;

  // Control flags that walk down the row of cells with a pixel.
  typedef struct packed {
    logic valid;
    logic coarse_hit;
    logic fine_hit;
  } apcm_flags_t;

  // Top two bits of red, green and blue.
  function automatic logic [CoarseKeyW-1:0] coarse_key(input logic [RgbW-1:0] rgb);
    coarse_key = {rgb[23:22], rgb[15:14], rgb[7:6]};
  endfunction

  // Top bit of red, green and blue.
  function automatic logic [FineKeyW-1:0] fine_key(input logic [RgbW-1:0] rgb);
    fine_key = {rgb[23], rgb[15], rgb[7]};
  endfunction

endpackage

`default_nettype wire

// ===== hdl/adaptive_palette_color_matcher.sv =====
// Top level: row of palette cells feeding the decision controller.
//
//  Channel  | Dir | Signals                        | Payload
//  ---------+-----+--------------------------------+------------------------------------------
//  s_axis   | in  | tvalid, tready, tdata[31:0]    | pixel (ARGB, alpha ignored)
//  m_axis   | out | tvalid, tready, tdata[39:0],   | tdata: color_index, added_color,
//           |     | tuser[1:0]                     |   used_entries; tuser: added, fallback
//
// A pixel walks the row one cell per cycle; its result passes the controller's pending
// register and then the output register before it is offered on m_axis, and the next
// pixel is taken in the cycle after that result lands in the output register, so only one
// pixel is in the row at a time. A stalled output beat holds the finished pixel in the
// controller; the next input beat can still be taken while the previous result waits.
// Reset empties the palette at once; stored colors are not cleared since entries beyond the
// fill count are never compared.
`timescale 1ns / 1ps
`default_nettype none

module adaptive_palette_color_matcher
  import apcm_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = PaletteEntriesDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [PixelW-1:0]   s_axis_tdata,   // [31:0] pixel
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata,   // [3:0] color_index, [27:4] added_color,
                                                   // [32:28] used_entries, [39:33] zero
  output logic [OutUserW-1:0]      m_axis_tuser    // [0] entry_added, [1] fallback
);

  localparam int unsigned IdxW = $clog2(PALETTE_ENTRIES);
  localparam int unsigned CntW = $clog2(PALETTE_ENTRIES + 1);

  apcm_flags_t     tok_w  [PALETTE_ENTRIES+1];
  logic [RgbW-1:0] pix_w  [PALETTE_ENTRIES+1];
  logic [IdxW-1:0] cidx_w [PALETTE_ENTRIES+1];
  logic [IdxW-1:0] fidx_w [PALETTE_ENTRIES+1];

  logic            busy;
  logic            in_accept;
  logic [CntW-1:0] count;
  logic            wr_en;
  logic [IdxW-1:0] wr_idx;
  logic [RgbW-1:0] wr_rgb;

  assign s_axis_tready = !busy;
  assign in_accept     = s_axis_tvalid && !busy;

  assign tok_w[0]  = '{valid: in_accept, coarse_hit: 1'b0, fine_hit: 1'b0};
  assign pix_w[0]  = s_axis_tdata[RgbW-1:0];
  assign cidx_w[0] = '0;
  assign fidx_w[0] = '0;

  for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_cell
    apcm_cell #(
      .Entries (PALETTE_ENTRIES),
      .Index   (i)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .tok_i    (tok_w[i]),
      .pix_i    (pix_w[i]),
      .cidx_i   (cidx_w[i]),
      .fidx_i   (fidx_w[i]),
      .count_i  (count),
      .wr_en_i  (wr_en),
      .wr_idx_i (wr_idx),
      .wr_rgb_i (wr_rgb),
      .tok_o    (tok_w[i+1]),
      .pix_o    (pix_w[i+1]),
      .cidx_o   (cidx_w[i+1]),
      .fidx_o   (fidx_w[i+1])
    );
  end

  apcm_ctrl #(
    .Entries (PALETTE_ENTRIES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .busy_o      (busy),
    .tok_i       (tok_w[PALETTE_ENTRIES]),
    .pix_i       (pix_w[PALETTE_ENTRIES]),
    .cidx_i      (cidx_w[PALETTE_ENTRIES]),
    .fidx_i      (fidx_w[PALETTE_ENTRIES]),
    .count_o     (count),
    .wr_en_o     (wr_en),
    .wr_idx_o    (wr_idx),
    .wr_rgb_o    (wr_rgb),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ===== hdl/apcm_cell.sv =====
// One palette cell: holds an entry, compares the passing pixel and hands it on.
`timescale 1ns / 1ps
`default_nettype none

module apcm_cell
  import apcm_pkg::*;
#(
  parameter int unsigned Entries = PaletteEntriesDefault,
  parameter int unsigned Index   = 0,
  localparam int unsigned IdxW   = $clog2(Entries),
  localparam int unsigned CntW   = $clog2(Entries + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire apcm_flags_t       tok_i,
  input  wire logic [RgbW-1:0]   pix_i,
  input  wire logic [IdxW-1:0]   cidx_i,
  input  wire logic [IdxW-1:0]   fidx_i,
  input  wire logic [CntW-1:0]   count_i,
  input  wire logic              wr_en_i,
  input  wire logic [IdxW-1:0]   wr_idx_i,
  input  wire logic [RgbW-1:0]   wr_rgb_i,
  output apcm_flags_t            tok_o,
  output logic [RgbW-1:0]        pix_o,
  output logic [IdxW-1:0]        cidx_o,
  output logic [IdxW-1:0]        fidx_o
);

  logic [RgbW-1:0] entry_q;
  logic            used;
  logic            hit_c;
  logic            hit_f;
  apcm_flags_t     tok_d, tok_q;
  logic [IdxW-1:0] cidx_d, fidx_d;
  logic [RgbW-1:0] pix_q;
  logic [IdxW-1:0] cidx_q, fidx_q;

  // Only entries below the fill count take part in the compare; the rest may hold stale colors.
  assign used  = count_i > CntW'(Index);
  assign hit_c = used && (coarse_key(entry_q) == coarse_key(pix_i));
  assign hit_f = used && (fine_key(entry_q) == fine_key(pix_i));

  always_comb begin
    tok_d            = tok_i;
    tok_d.coarse_hit = tok_i.coarse_hit | hit_c;
    tok_d.fine_hit   = tok_i.fine_hit | hit_f;
    // Earlier cells keep priority, so the lowest matching index survives.
    cidx_d = tok_i.coarse_hit ? cidx_i : IdxW'(Index);
    fidx_d = tok_i.fine_hit ? fidx_i : IdxW'(Index);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_idx_i == IdxW'(Index))) begin
      entry_q <= wr_rgb_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q  <= pix_i;
    cidx_q <= cidx_d;
    fidx_q <= fidx_d;
  end

  assign tok_o  = tok_q;
  assign pix_o  = pix_q;
  assign cidx_o = cidx_q;
  assign fidx_o = fidx_q;

endmodule

`default_nettype wire

// ===== hdl/apcm_ctrl.sv =====
// Controller: takes the pixel from the end of the row, decides, grows the palette, drives results.
`timescale 1ns / 1ps
`default_nettype none

module apcm_ctrl
  import apcm_pkg::*;
#(
  parameter int unsigned Entries = PaletteEntriesDefault,
  localparam int unsigned IdxW   = $clog2(Entries),
  localparam int unsigned CntW   = $clog2(Entries + 1)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_accept_i,
  output logic                     busy_o,
  input  wire apcm_flags_t         tok_i,
  input  wire logic [RgbW-1:0]     pix_i,
  input  wire logic [IdxW-1:0]     cidx_i,
  input  wire logic [IdxW-1:0]     fidx_i,
  output logic [CntW-1:0]          count_o,
  output logic                     wr_en_o,
  output logic [IdxW-1:0]          wr_idx_o,
  output logic [RgbW-1:0]          wr_rgb_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [OutDataW-1:0]      out_data_o,
  output logic [OutUserW-1:0]      out_user_o
);

  logic                busy_q;
  logic                pend_valid_q;
  apcm_flags_t         pend_tok_q;
  logic [RgbW-1:0]     pend_pix_q;
  logic [IdxW-1:0]     pend_cidx_q, pend_fidx_q;
  logic [CntW-1:0]     count_q, count_d;
  logic                res_load;
  logic [IdxW-1:0]     idx;
  logic                added;
  logic                fb;
  logic [RgbW-1:0]     color;
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic [OutUserW-1:0] out_user_q;

  assign res_load = pend_valid_q && (!out_valid_q || out_ready_i);

  always_comb begin
    idx   = pend_cidx_q;
    added = 1'b0;
    fb    = 1'b0;
    color = '0;
    if (pend_tok_q.coarse_hit) begin
      idx = pend_cidx_q;
    end else if (count_q < CntW'(Entries)) begin
      idx   = count_q[IdxW-1:0];
      added = 1'b1;
      color = pend_pix_q;
    end else if (pend_tok_q.fine_hit) begin
      idx = pend_fidx_q;
    end else begin
      idx = IdxW'(Entries - 1);
      fb  = 1'b1;
    end
    count_d = count_q + CntW'(added);
  end

  assign wr_en_o  = res_load && added;
  assign wr_idx_o = idx;
  assign wr_rgb_o = pend_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_accept_i) begin
        busy_q <= 1'b1;
      end else if (res_load) begin
        busy_q <= 1'b0;
      end
      if (tok_i.valid) begin
        pend_valid_q <= 1'b1;
      end else if (res_load) begin
        pend_valid_q <= 1'b0;
      end
      if (res_load) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_i.valid) begin
      pend_tok_q  <= tok_i;
      pend_pix_q  <= pix_i;
      pend_cidx_q <= cidx_i;
      pend_fidx_q <= fidx_i;
    end
    if (res_load) begin
      out_data_q <= OutDataW'({UsedW'(count_d), color, IdxOutW'(idx)});
      out_user_q[UserAddedBit]    <= added;
      out_user_q[UserFallbackBit] <= fb;
    end
  end

  assign busy_o      = busy_q;
  assign count_o     = count_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

  // The fill count never runs past the palette size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Entries))
    else $error("palette count beyond palette size");

  // Adding an entry bumps the count by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_load && added) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("palette count did not follow an added entry");

  // Fallback is only possible with a full palette.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_load && fb) |-> (count_q == CntW'(Entries)))
    else $error("fallback with free palette entries");

  // A pixel waiting for the result register belongs to the item in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> busy_q)
    else $error("pending pixel while idle");

endmodule

`default_nettype wire
